FILE: rtl/plist_pkg.sv
// shared types and constants of the positional list store
package plist_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;

    // stream payload layout
    localparam int IN_W      = 40;
    localparam int OUT_W     = 40;
    localparam int OUT_PAD_W = OUT_W - DATA_W - CNT_W - ST_W;

    typedef logic [OP_W-1:0]          op_t;
    typedef logic [ST_W-1:0]          status_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam op_t OP_PUSH_BACK  = 3'd0;
    localparam op_t OP_PUSH_FRONT = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_INSERT     = 3'd4;
    localparam op_t OP_REMOVE     = 3'd5;
    localparam op_t OP_READ       = 3'd6;
    localparam op_t OP_CLEAR      = 3'd7;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    // broadcast to every cell of the row
    typedef struct packed {
        logic  ins;
        logic  rem;
        data_t value;
    } cell_cmd_t;

endpackage

FILE: rtl/positional_list_store_core.sv
// top level of the positional list store: cell row, request decode, result register
//
// bounded ordered list of signed 32-bit words held in a row of CAPACITY cells
// s_ channel carries one request: push back/front, pop front/back, insert,
//   remove, read at a position, or clear
// m_ channel returns exactly one result per request: word read or popped,
//   count after the request, and a status (ok, full, empty, index out of range)
// a request that cannot be served leaves the list unchanged
// throughput: one request per cycle while the receiver takes results; every cell
//   compares its own slot with the broadcast position and shifts in the same cycle,
//   so insert and remove cost no more than a read
// the result appears on m_ in the cycle after the request is taken
// the result sits in an output register; a new request is taken while that
//   register is empty or being drained in the same cycle
// when the receiver stalls m_tvalid holds with a stable payload and s_tready
//   drops until the result is taken
// reset clears the fill count and the output valid; stored words are left
//   as they are and are never read before being written
// a count above 31 (CAPACITY above 31) is reported modulo 32
module positional_list_store_core
    import plist_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    // request channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // op[2:0], value[34:3], index[39:35]
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // read_data[31:0], count[36:32], status[38:37], pad
);

    localparam int POS_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int EXT_W  = FILL_W + IDX_W;

    // request fields
    op_t              req_op;
    data_t            req_value;
    logic [IDX_W-1:0] req_index;

    assign req_op    = s_tdata[OP_W-1:0];
    assign req_value = s_tdata[OP_W+DATA_W-1:OP_W];
    assign req_index = s_tdata[OP_W+DATA_W+IDX_W-1:OP_W+DATA_W];

    // list state
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    data_t             entries [CAPACITY];

    // result register
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    data_t             read_data_reg;
    logic [CNT_W-1:0]  count_reg;
    status_t           status_reg;

    // decode
    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic [EXT_W-1:0]  fill_ext;
    logic [EXT_W-1:0]  idx_ext;
    logic [EXT_W-1:0]  pos_ext;
    logic [POS_W-1:0]  pos;
    logic              do_ins;
    logic              do_take;
    logic              do_ret;
    logic              do_clear;
    status_t           status_new;
    data_t             read_new;
    logic [FILL_W+CNT_W-1:0] cnt_ext;
    cell_cmd_t         cmd;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_full  = (fill_reg == FILL_W'(CAPACITY));
    assign is_empty = (fill_reg == '0);
    assign fill_ext = {{IDX_W{1'b0}}, fill_reg};
    assign idx_ext  = {{FILL_W{1'b0}}, req_index};

    always_comb begin
        pos_ext    = '0;
        do_ins     = 1'b0;
        do_take    = 1'b0;
        do_ret     = 1'b0;
        do_clear   = 1'b0;
        status_new = ST_OK;
        unique case (req_op)
            OP_PUSH_BACK: begin
                pos_ext = fill_ext;
                if (is_full) status_new = ST_FULL;
                else         do_ins     = 1'b1;
            end
            OP_PUSH_FRONT: begin
                if (is_full) status_new = ST_FULL;
                else         do_ins     = 1'b1;
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    status_new = ST_EMPTY;
                end else begin
                    do_take = 1'b1;
                    do_ret  = 1'b1;
                end
            end
            OP_POP_BACK: begin
                pos_ext = fill_ext - EXT_W'(1);
                if (is_empty) begin
                    status_new = ST_EMPTY;
                end else begin
                    do_take = 1'b1;
                    do_ret  = 1'b1;
                end
            end
            OP_INSERT: begin
                pos_ext = idx_ext;
                // fullness wins over a bad position
                if (is_full)                  status_new = ST_FULL;
                else if (idx_ext > fill_ext)  status_new = ST_RANGE;
                else                          do_ins     = 1'b1;
            end
            OP_REMOVE: begin
                pos_ext = idx_ext;
                if (is_empty)                 status_new = ST_EMPTY;
                else if (idx_ext >= fill_ext) status_new = ST_RANGE;
                else                          do_take    = 1'b1;
            end
            OP_READ: begin
                pos_ext = idx_ext;
                if (is_empty)                 status_new = ST_EMPTY;
                else if (idx_ext >= fill_ext) status_new = ST_RANGE;
                else                          do_ret     = 1'b1;
            end
            OP_CLEAR: begin
                do_clear = 1'b1;
            end
            default: begin
                status_new = ST_OK;
            end
        endcase
    end

    assign pos      = pos_ext[POS_W-1:0];
    // word is picked before the row shifts
    assign read_new = do_ret ? entries[pos] : '0;

    assign cmd.ins   = accept && do_ins;
    assign cmd.rem   = accept && do_take;
    assign cmd.value = req_value;

    // cell row: cells see their neighbors, cell 0 the request value, the last cell itself
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        data_t left_d;
        data_t right_d;
        if (g == 0) begin : g_first
            assign left_d = req_value;
        end else begin : g_inner_l
            assign left_d = entries[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_d = entries[g];
        end else begin : g_inner_r
            assign right_d = entries[g+1];
        end
        plist_cell #(
            .POS_W (POS_W),
            .SLOT  (g)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .pos        (pos),
            .left_data  (left_d),
            .right_data (right_d),
            .entry_data (entries[g])
        );
    end

    always_comb begin
        fill_next = fill_reg;
        if (accept) begin
            priority if (do_clear) fill_next = '0;
            else if (do_ins)       fill_next = fill_reg + FILL_W'(1);
            else if (do_take)      fill_next = fill_reg - FILL_W'(1);
            else                   fill_next = fill_reg;
        end
    end

    assign cnt_ext = {{CNT_W{1'b0}}, fill_next};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)        m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload of the result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg <= read_new;
            count_reg     <= cnt_ext[CNT_W-1:0];
            status_reg    <= status_new;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, status_reg, count_reg, read_data_reg};

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("fill count above capacity");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req_op == OP_CLEAR) |=> m_tvalid_reg && (count_reg == '0)
            && (status_reg == ST_OK))
        else $error("clear did not report an empty list");

    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (status_reg != ST_OK) |-> (read_data_reg == '0))
        else $error("failed request returned a word");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (status_reg == ST_EMPTY) |-> (count_reg == '0))
        else $error("empty status with nonzero count");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(fill_reg))
        else $error("list changed while result stalled");

endmodule

FILE: rtl/plist_cell.sv
// one storage cell of the list row, shifts toward either neighbor
module plist_cell
    import plist_pkg::*;
#(
    parameter int POS_W = 4,
    parameter int SLOT  = 0
) (
    input  logic             aclk,
    input  cell_cmd_t        cmd,
    input  logic [POS_W-1:0] pos,
    input  data_t            left_data,
    input  data_t            right_data,
    output data_t            entry_data
);

    localparam logic [POS_W-1:0] SLOT_POS = POS_W'(SLOT);

    data_t entry_reg;
    data_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        priority if (cmd.ins && (SLOT_POS == pos)) begin
            entry_next = cmd.value;
        end else if (cmd.ins && (SLOT_POS > pos)) begin
            entry_next = left_data;
        end else if (cmd.rem && (SLOT_POS >= pos)) begin
            entry_next = right_data;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_data = entry_reg;

endmodule
